@@ rtl/core/mrcfw_pkg.sv @@
// shared constants, command codes and the crc byte update for the motor reply checker
package mrcfw_pkg;

  // command codes carried in the cmd field
  localparam logic [1:0] CMD_ACK  = 2'd0;
  localparam logic [1:0] CMD_BYTE = 2'd1;
  localparam logic [1:0] CMD_EVAL = 2'd2;
  localparam logic [1:0] CMD_NONE = 2'd3;

  // parameter defaults
  localparam int WINDOW_LEN_DEF = 50;
  localparam int CRC_BYTES_DEF  = 45;
  localparam int MOTORS_DEF     = 2;

  // fixed field widths
  localparam int CMD_W    = 2;
  localparam int MOTOR_W  = 1;
  localparam int BYTE_W   = 8;
  localparam int COUNT_W  = 6;
  localparam int THRESH_W = 6;
  localparam int CRC_W    = 16;
  localparam int POS_W    = 32;

  // per-motor state slots addressed by the motor field
  localparam int MOTOR_SLOTS = 1 << MOTOR_W;

  // acknowledge codes
  localparam logic [BYTE_W-1:0] ACK_NONE      = 8'hFF;
  localparam logic [BYTE_W-1:0] ACK_ERR_ABOVE = 8'h80;

  // crc constants
  localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
  localparam logic [CRC_W-1:0] CRC_POLY = 16'hA001;

  // reply byte positions holding the big-endian position
  localparam int POS_FIRST = 11;
  localparam int POS_LAST  = 14;

  // reset value of the fault threshold
  localparam logic [THRESH_W-1:0] THRESH_RESET = 6'd45;

  // one byte of reflected modbus crc-16
  function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                 input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < BYTE_W; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

@@ rtl/core/motor_reply_checker_fault_window.sv @@
// top level of the motor reply checker with shared fault window
//
// Channels: in_* carries one item per handshake (cmd, motor, data_byte,
// frame_start). Acknowledge items (cmd 0) store a motor's function code,
// reply items (cmd 1) feed that motor's crc, byte count and position, and
// evaluate items (cmd 2) give one result on out_*: motor, frame good, fatal
// flag, window error count and captured position. Other items give none.
// cfg_* writes the fault threshold and is always ready; the user must write it
// only while no item is in flight, as the block itself does not enforce this.
// Path: an accepted item is registered in the input register and processed
// from there; an evaluate item's result is then held in the result register.
// Throughput: one item per cycle while the input channel does not stall; the
// crc byte update and window count between the two registers are combinational.
// Stall: while a result waits for out_ready, items without a result still
// pass; an evaluate item waits in the input register, and the input channel
// stalls only once that register is also full.
// Reset (rst_n low, synchronous): no item in flight, crc 0xFFFF, counts and
// position zero, acknowledge 0xFF, window empty, fatal 0, threshold 45.
module motor_reply_checker_fault_window
  import mrcfw_pkg::*;
#(
  parameter int WINDOW_LEN = WINDOW_LEN_DEF,
  parameter int CRC_BYTES  = CRC_BYTES_DEF,
  parameter int MOTORS     = MOTORS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // input item channel
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [CMD_W-1:0]           in_cmd,
  input  logic [MOTOR_W-1:0]         in_motor,
  input  logic [BYTE_W-1:0]          in_data_byte,
  input  logic                       in_frame_start,
  // result channel
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [MOTOR_W-1:0]         out_which_motor,
  output logic                       out_frame_good,
  output logic                       out_fatal,
  output logic [COUNT_W-1:0]         out_error_count,
  output logic signed [POS_W-1:0]    out_position_raw,
  // configuration write channel
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [THRESH_W-1:0]        cfg_fault_threshold
);

  localparam int FRAME_LEN = CRC_BYTES + 2;
  localparam int CNT_W     = $clog2(FRAME_LEN + 1);

  // input register
  logic                 in_valid_r;
  logic [CMD_W-1:0]     cmd_r;
  logic [MOTOR_W-1:0]   motor_r;
  logic [BYTE_W-1:0]    byte_r;
  logic                 start_r;

  // per-motor frame state
  logic [CRC_W-1:0]     crc_r      [MOTOR_SLOTS];
  logic [CRC_W-1:0]     crc_nxt    [MOTOR_SLOTS];
  logic [CNT_W-1:0]     cnt_r      [MOTOR_SLOTS];
  logic [CNT_W-1:0]     cnt_nxt    [MOTOR_SLOTS];
  logic [CRC_W-1:0]     rxcrc_r    [MOTOR_SLOTS];
  logic [CRC_W-1:0]     rxcrc_nxt  [MOTOR_SLOTS];
  logic [POS_W-1:0]     pos_r      [MOTOR_SLOTS];
  logic [POS_W-1:0]     pos_nxt    [MOTOR_SLOTS];
  logic [BYTE_W-1:0]    ack_r      [MOTOR_SLOTS];
  logic [BYTE_W-1:0]    ack_nxt    [MOTOR_SLOTS];

  // shared window state
  logic [WINDOW_LEN-1:0] win_r, win_nxt;
  logic [COUNT_W-1:0]    total_r, total_nxt;
  logic                  fatal_r, fatal_nxt;
  logic [THRESH_W-1:0]   thresh_r;

  // result register
  logic                 out_valid_r;
  logic [MOTOR_W-1:0]   res_motor_r;
  logic                 res_good_r;
  logic                 res_fatal_r;
  logic [COUNT_W-1:0]   res_count_r;
  logic [POS_W-1:0]     res_pos_r;

  // processing controls
  logic                 motor_ok;
  logic                 is_eval;
  logic                 advance;
  logic                 frame_good;
  logic [CNT_W-1:0]     cnt_cur;
  logic [CRC_W-1:0]     crc_cur;

  // handshake
  assign motor_ok  = (32'(motor_r) < MOTORS);
  assign is_eval   = motor_ok && (cmd_r == CMD_EVAL);
  assign advance   = in_valid_r && (!is_eval || !out_valid_r || out_ready);
  assign in_ready  = !in_valid_r || advance;
  assign cfg_ready = 1'b1;

  // judgement of the selected motor's frame
  assign frame_good = (cnt_r[motor_r] >= CNT_W'(FRAME_LEN))
                   && (crc_r[motor_r] == rxcrc_r[motor_r])
                   && (ack_r[motor_r] <= ACK_ERR_ABOVE);

  // next state of the per-motor registers
  always_comb begin
    crc_nxt   = crc_r;
    cnt_nxt   = cnt_r;
    rxcrc_nxt = rxcrc_r;
    pos_nxt   = pos_r;
    ack_nxt   = ack_r;
    cnt_cur   = start_r ? '0 : cnt_r[motor_r];
    crc_cur   = start_r ? CRC_INIT : crc_r[motor_r];
    if (advance && motor_ok) begin
      unique case (cmd_r)
        CMD_ACK: begin
          ack_nxt[motor_r] = byte_r;
        end
        CMD_BYTE: begin
          crc_nxt[motor_r] = crc_cur;
          cnt_nxt[motor_r] = cnt_cur;
          if (cnt_cur < CNT_W'(FRAME_LEN)) begin
            if (cnt_cur < CNT_W'(CRC_BYTES)) begin
              crc_nxt[motor_r] = crc_byte(crc_cur, byte_r);
            end else if (cnt_cur == CNT_W'(CRC_BYTES)) begin
              rxcrc_nxt[motor_r] = {rxcrc_r[motor_r][CRC_W-1:BYTE_W], byte_r};
            end else begin
              rxcrc_nxt[motor_r] = {byte_r, rxcrc_r[motor_r][BYTE_W-1:0]};
            end
            if ((cnt_cur >= CNT_W'(POS_FIRST)) && (cnt_cur <= CNT_W'(POS_LAST))) begin
              pos_nxt[motor_r] = {pos_r[motor_r][POS_W-BYTE_W-1:0], byte_r};
            end
            cnt_nxt[motor_r] = cnt_cur + CNT_W'(1);
          end
        end
        CMD_EVAL: begin
          ack_nxt[motor_r] = ACK_NONE;
        end
        CMD_NONE: begin
        end
        default: begin
        end
      endcase
    end
  end

  // window shift line, error total and fatal flag
  always_comb begin
    win_nxt   = win_r;
    total_nxt = total_r;
    fatal_nxt = fatal_r;
    if (advance && is_eval) begin
      win_nxt   = {win_r[WINDOW_LEN-2:0], !frame_good};
      total_nxt = total_r - COUNT_W'(win_r[WINDOW_LEN-1]) + COUNT_W'(!frame_good);
      fatal_nxt = (total_nxt > thresh_r);
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
    if (in_ready && in_valid) begin
      cmd_r   <= in_cmd;
      motor_r <= in_motor;
      byte_r  <= in_data_byte;
      start_r <= in_frame_start;
    end
  end

  // per-motor and window state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < MOTOR_SLOTS; s++) begin
        crc_r[s]   <= CRC_INIT;
        cnt_r[s]   <= '0;
        rxcrc_r[s] <= '0;
        pos_r[s]   <= '0;
        ack_r[s]   <= ACK_NONE;
      end
      win_r    <= '0;
      total_r  <= '0;
      fatal_r  <= 1'b0;
      thresh_r <= THRESH_RESET;
    end else begin
      crc_r   <= crc_nxt;
      cnt_r   <= cnt_nxt;
      rxcrc_r <= rxcrc_nxt;
      pos_r   <= pos_nxt;
      ack_r   <= ack_nxt;
      win_r   <= win_nxt;
      total_r <= total_nxt;
      fatal_r <= fatal_nxt;
      if (cfg_valid && cfg_ready) begin
        thresh_r <= cfg_fault_threshold;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && is_eval) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (advance && is_eval) begin
      res_motor_r <= motor_r;
      res_good_r  <= frame_good;
      res_fatal_r <= fatal_nxt;
      res_count_r <= total_nxt;
      res_pos_r   <= pos_r[motor_r];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_which_motor  = res_motor_r;
  assign out_frame_good   = res_good_r;
  assign out_fatal        = res_fatal_r;
  assign out_error_count  = res_count_r;
  assign out_position_raw = signed'(res_pos_r);

`ifndef SYNTHESIS
  // running total always matches the bad entries held in the window
  a_total_matches: assert property (@(posedge clk) disable iff (!rst_n)
    32'(total_r) == $countones(win_r))
    else $error("window total out of step with window contents");

  // a pending result agrees with the threshold it was judged against
  a_fatal_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (res_fatal_r == (res_count_r > thresh_r)))
    else $error("fatal flag inconsistent with error count");

  // an item held in the input register is not lost while it waits
  a_item_held: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && !advance) |=> (in_valid_r && $stable(cmd_r) && $stable(motor_r)))
    else $error("waiting item dropped from input register");

  // an evaluate item that moves on always leaves a result behind
  a_eval_result: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && is_eval) |=> out_valid_r)
    else $error("evaluate item gave no result");
`endif

endmodule
